// ===== design/pwt_pkg.sv =====
// ----------------------------------------------------------------------------
// pwt_pkg
// shared types, codes and helpers of the four-level page table walker
// ----------------------------------------------------------------------------
package pwt_pkg;

  localparam int LEVEL_ENTRIES = 512;
  localparam int IDX_W         = $clog2(LEVEL_ENTRIES);
  localparam int QUEUE_DEPTH   = 2;

  // item modes
  localparam logic [1:0] MODE_WRITE     = 2'd0;
  localparam logic [1:0] MODE_TRANSLATE = 2'd1;
  localparam logic [1:0] MODE_UNMAP     = 2'd2;
  localparam logic [1:0] MODE_MAP       = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ABSENT     = 3'd1;
  localparam logic [2:0] ST_MISALIGNED = 3'd2;
  localparam logic [2:0] ST_CONFLICT   = 3'd3;
  localparam logic [2:0] ST_OUTSIDE    = 3'd4;

  // entry bits
  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;
  localparam int BIT_NX      = 63;

  // command kinds handed from front to back
  typedef enum logic [1:0] {
    OP_DONE  = 2'd0,  // status already known
    OP_WRITE = 2'd1,  // plain store write
    OP_WALK  = 2'd2   // table walk
  } op_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] word_index;
    logic [63:0] word_value;
    logic [63:0] virt_addr;
    logic [51:0] phys_addr;
    logic [11:0] page_flags;
    logic        no_execute;
  } pwt_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [51:0] phys_out;
    logic        large_page;
  } pwt_res_t;

  typedef struct packed {
    op_e         op;
    logic [1:0]  mode;
    logic [2:0]  status;     // for OP_DONE
    logic [11:0] word_index; // for OP_WRITE
    logic [63:0] data;       // write value or new page entry
    logic [47:0] va;
    logic [39:0] root_page;  // root table base bits 51:12
  } pwt_cmd_t;

  // 9-bit table index of the walk level
  function automatic logic [IDX_W-1:0] level_idx(input logic [47:0] va,
                                                 input logic [1:0]  lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

// ===== design/pwt_front.sv =====
// ----------------------------------------------------------------------------
// pwt_front
// classifies an accepted item into a command for the walk engine
// ----------------------------------------------------------------------------
module pwt_front #(
  parameter int TABLE_WORDS = 4096
) (
  input  pwt_pkg::pwt_req_t req_i,
  input  logic [51:0]       root_base_i,
  output pwt_pkg::pwt_cmd_t cmd_o
);
  import pwt_pkg::*;

  logic misaligned;
  logic idx_inside;

  assign misaligned = (req_i.virt_addr[11:0] != 12'd0) || (req_i.phys_addr[11:0] != 12'd0);
  assign idx_inside = 17'(req_i.word_index) < 17'(TABLE_WORDS);

  always_comb begin
    cmd_o            = '0;
    cmd_o.mode       = req_i.mode;
    cmd_o.word_index = req_i.word_index;
    cmd_o.va         = req_i.virt_addr[47:0];
    cmd_o.root_page  = root_base_i[51:12];
    cmd_o.status     = ST_OK;
    if (req_i.mode == MODE_MAP) begin
      cmd_o.data = {req_i.no_execute, 11'd0, req_i.phys_addr[51:12], req_i.page_flags};
      cmd_o.data[BIT_PRESENT] = 1'b1;
    end else begin
      cmd_o.data = req_i.word_value;
    end
    priority if (req_i.mode == MODE_WRITE) begin
      cmd_o.op     = idx_inside ? OP_WRITE : OP_DONE;
      cmd_o.status = idx_inside ? ST_OK : ST_OUTSIDE;
    end else if (req_i.mode == MODE_MAP && misaligned) begin
      cmd_o.op     = OP_DONE;
      cmd_o.status = ST_MISALIGNED;
    end else if (root_base_i == 52'd0) begin
      cmd_o.op     = OP_DONE;
      cmd_o.status = ST_ABSENT;
    end else begin
      cmd_o.op = OP_WALK;
    end
  end

endmodule

// ===== design/pwt_queue.sv =====
// ----------------------------------------------------------------------------
// pwt_queue
// short command queue between front and walk engine
// ----------------------------------------------------------------------------
module pwt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pwt_pkg::pwt_cmd_t cmd_i,
  input  logic              pop_i,
  output pwt_pkg::pwt_cmd_t cmd_o,
  output logic              empty_o,
  output logic              full_o
);
  import pwt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pwt_cmd_t          entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign cmd_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== design/pwt_back.sv =====
// ----------------------------------------------------------------------------
// pwt_back
// walk engine: owns the table store, runs walks, writes and the reset clear
// ----------------------------------------------------------------------------
module pwt_back #(
  parameter int TABLE_WORDS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pwt_pkg::pwt_cmd_t cmd_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              clearing_o,
  output logic              res_valid_o,
  output pwt_pkg::pwt_res_t res_o
);
  import pwt_pkg::*;

  localparam int AW = $clog2(TABLE_WORDS);
  localparam logic [48:0] TW = 49'(TABLE_WORDS);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;

  logic [63:0]   store_q [TABLE_WORDS];
  logic [63:0]   rdata_q;

  logic [1:0]    state_q, state_d;
  logic [1:0]    lvl_q, lvl_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;
  logic [AW-1:0] addr_q, addr_d;
  pwt_cmd_t      cur_q, cur_d;
  pwt_res_t      res_q, res_d;
  logic          res_valid_q, res_valid_d;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [63:0]   wr_data;

  logic [48:0]   first_word;
  logic [48:0]   next_word;
  logic [63:0]   ent;

  assign first_word  = {cmd_i.root_page, level_idx(cmd_i.va, 2'd0)};
  assign ent         = rdata_q;
  assign next_word   = {ent[51:12], level_idx(cur_q.va, lvl_q + 2'd1)};
  assign clearing_o  = (state_q == S_CLEAR);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    clr_addr_d  = clr_addr_q;
    addr_d      = addr_q;
    cur_d       = cur_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    pop_o       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = addr_q;
    wr_en       = 1'b0;
    wr_addr     = addr_q;
    wr_data     = '0;

    unique case (state_q)
      S_CLEAR: begin
        wr_en      = 1'b1;
        wr_addr    = clr_addr_q;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(TABLE_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (!empty_i) begin
          pop_o       = 1'b1;
          cur_d       = cmd_i;
          res_d       = '0;
          res_d.status = ST_OK;
          unique case (cmd_i.op)
            OP_WRITE: begin
              wr_en       = 1'b1;
              wr_addr     = AW'(cmd_i.word_index);
              wr_data     = cmd_i.data;
              res_valid_d = 1'b1;
            end
            OP_WALK: begin
              if (first_word >= TW) begin
                res_d.status = ST_OUTSIDE;
                res_valid_d  = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = first_word[AW-1:0];
                addr_d  = first_word[AW-1:0];
                lvl_d   = 2'd0;
                state_d = S_WALK;
              end
            end
            default: begin
              res_d.status = cmd_i.status;
              res_valid_d  = 1'b1;
            end
          endcase
        end
      end

      S_WALK: begin
        res_d        = '0;
        res_d.status = ST_OK;
        state_d      = S_IDLE;
        priority if (!ent[BIT_PRESENT]) begin
          res_d.status = ST_ABSENT;
          res_valid_d  = 1'b1;
        end else if (lvl_q == 2'd3) begin
          res_d.phys_out = {ent[51:12], cur_q.va[11:0]};
          res_valid_d    = 1'b1;
        end else if (lvl_q == 2'd2 && ent[BIT_LARGE]) begin
          // 2MB page at the PD level
          res_valid_d = 1'b1;
          unique case (cur_q.mode)
            MODE_TRANSLATE: begin
              res_d.phys_out   = {ent[51:21], cur_q.va[20:0]};
              res_d.large_page = 1'b1;
            end
            MODE_UNMAP: begin
              wr_en            = 1'b1;
              wr_addr          = addr_q;
              res_d.large_page = 1'b1;
            end
            default: begin
              res_d.status = ST_CONFLICT;
            end
          endcase
        end else if (next_word >= TW) begin
          res_d.status = ST_OUTSIDE;
          res_valid_d  = 1'b1;
        end else if (lvl_q != 2'd2 || cur_q.mode == MODE_TRANSLATE) begin
          rd_en   = 1'b1;
          rd_addr = next_word[AW-1:0];
          addr_d  = next_word[AW-1:0];
          lvl_d   = lvl_q + 2'd1;
          state_d = S_WALK;
        end else begin
          // PT entry of unmap or map
          wr_en       = 1'b1;
          wr_addr     = next_word[AW-1:0];
          wr_data     = (cur_q.mode == MODE_MAP) ? cur_q.data : 64'd0;
          res_valid_d = 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      lvl_q       <= '0;
      clr_addr_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      clr_addr_q  <= clr_addr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    cur_q  <= cur_d;
    res_q  <= res_d;
  end

  // table store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= store_q[rd_addr];
    end
  end

endmodule

// ===== design/four_level_page_table_walker_top.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top
// x86-64 four-level page walker over a local table store
// ----------------------------------------------------------------------------
// results: store writes and early rejects pass the queue and give their result
//   from the walk engine's idle state; walks add one store read per table level
// flow: the engine takes the next queued transaction only when idle; a full
//   4KB translate reads level by level through the store's single read port
// reset: a clearing pass zeroes every store word with busy high;
//   results are strobed for one cycle and the receiver cannot stall
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top #(
  parameter int TABLE_WORDS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // item channel
  input  logic              start,
  output logic              busy,
  input  pwt_pkg::pwt_req_t req_i,
  // result channel
  output logic              res_valid_o,
  output pwt_pkg::pwt_res_t res_o,
  // root table base register
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [51:0]       cfg_data_i
);
  import pwt_pkg::*;

  logic [51:0] root_base_q;

  pwt_cmd_t front_cmd;
  pwt_cmd_t queue_cmd;
  logic     push;
  logic     pop;
  logic     q_empty;
  logic     q_full;
  logic     clearing;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      root_base_q <= cfg_data_i;
    end
  end

  // hold off new transactions while the queue is full or the store clears
  assign busy = q_full || clearing;
  assign push = start && !busy;

  // front: classify modes, catch misaligned maps, missing root, bad indexes
  pwt_front #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_front (
    .req_i       (req_i),
    .root_base_i (root_base_q),
    .cmd_o       (front_cmd)
  );

  // short queue lets the front take transactions while a walk runs
  pwt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (queue_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back: table store, level-by-level walk and the entry update
  pwt_back #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

// ===== sim/pwt_walk_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwt_walk_checker
// watches the item, result and root base channels of the page table walker,
// keeps a shadow copy of the table store and compares every result in order
// ----------------------------------------------------------------------------
module pwt_walk_checker #(
  parameter int TABLE_WORDS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  pwt_pkg::pwt_req_t req_i,
  input  logic              res_valid_i,
  input  pwt_pkg::pwt_res_t res_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [51:0]       cfg_data_i,
  output int                outstanding_o,
  output int                fail_count_o,
  output int                checked_o
);
  import pwt_pkg::*;

  localparam logic [63:0] ADDR_MASK       = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] LARGE_ADDR_MASK = 64'h000F_FFFF_FFE0_0000;
  localparam logic [63:0] LARGE_OFS_MASK  = 64'h0000_0000_001F_FFFF;
  localparam logic [63:0] PAGE_OFS_MASK   = 64'h0000_0000_0000_0FFF;

  logic [63:0] shadow_tables [TABLE_WORDS];
  logic [51:0] root_base;
  pwt_res_t    pending_results [$];
  int          fails;
  int          checked;

  // walk PML4, PDPT and PD; give back the PD word and its present entry
  function automatic logic [2:0] walk_to_pd(input logic [63:0] va,
                                            output logic [63:0] pd_word,
                                            output logic [63:0] pd_ent);
    logic [63:0] base;
    logic [63:0] word;
    logic [63:0] entry;
    logic [8:0]  idx;
    pd_word = '0;
    pd_ent  = '0;
    if (root_base == '0) return ST_ABSENT;
    base = {12'b0, root_base} & ADDR_MASK;
    for (int lvl = 0; lvl < 3; lvl++) begin
      idx  = 9'(va >> (39 - 9 * lvl));
      word = (base >> 3) + 64'(idx);
      if (word >= TABLE_WORDS) return ST_OUTSIDE;
      entry = shadow_tables[int'(word)];
      if (!entry[BIT_PRESENT]) return ST_ABSENT;
      base    = entry & ADDR_MASK;
      pd_word = word;
      pd_ent  = entry;
    end
    return ST_OK;
  endfunction

  function automatic logic [2:0] pt_entry_word(input logic [63:0] pd_ent,
                                               input logic [63:0] va,
                                               output logic [63:0] pt_word);
    pt_word = ((pd_ent & ADDR_MASK) >> 3) + 64'(va[20:12]);
    return (pt_word >= TABLE_WORDS) ? ST_OUTSIDE : ST_OK;
  endfunction

  // expected result of one item; updates the shadow store like the block does
  function automatic pwt_res_t predict_walk_result(input pwt_req_t r);
    pwt_res_t    res;
    logic [2:0]  st;
    logic [63:0] pd_word;
    logic [63:0] pd_ent;
    logic [63:0] pt_word;
    logic [63:0] pte;
    logic [63:0] phys;
    res  = '0;
    phys = '0;
    st   = ST_OK;
    case (r.mode)
      MODE_WRITE: begin
        if (r.word_index < TABLE_WORDS) shadow_tables[r.word_index] = r.word_value;
        else st = ST_OUTSIDE;
      end
      MODE_TRANSLATE: begin
        st = walk_to_pd(r.virt_addr, pd_word, pd_ent);
        if (st == ST_OK) begin
          if (pd_ent[BIT_LARGE]) begin
            phys = (pd_ent & LARGE_ADDR_MASK) | (r.virt_addr & LARGE_OFS_MASK);
            res.large_page = 1'b1;
          end else begin
            st = pt_entry_word(pd_ent, r.virt_addr, pt_word);
            if (st == ST_OK) begin
              pte = shadow_tables[int'(pt_word)];
              if (pte[BIT_PRESENT]) phys = (pte & ADDR_MASK) | (r.virt_addr & PAGE_OFS_MASK);
              else st = ST_ABSENT;
            end
          end
        end
      end
      MODE_UNMAP: begin
        st = walk_to_pd(r.virt_addr, pd_word, pd_ent);
        if (st == ST_OK) begin
          if (pd_ent[BIT_LARGE]) begin
            shadow_tables[int'(pd_word)] = '0;
            res.large_page = 1'b1;
          end else begin
            st = pt_entry_word(pd_ent, r.virt_addr, pt_word);
            if (st == ST_OK) shadow_tables[int'(pt_word)] = '0;
          end
        end
      end
      default: begin
        if (r.virt_addr[11:0] != '0 || r.phys_addr[11:0] != '0) begin
          st = ST_MISALIGNED;
        end else begin
          st = walk_to_pd(r.virt_addr, pd_word, pd_ent);
          if (st == ST_OK) begin
            if (pd_ent[BIT_LARGE]) begin
              st = ST_CONFLICT;
            end else begin
              st = pt_entry_word(pd_ent, r.virt_addr, pt_word);
              if (st == ST_OK)
                shadow_tables[int'(pt_word)] = {r.no_execute, 11'b0, r.phys_addr}
                                               | {52'b0, r.page_flags} | 64'd1;
            end
          end
        end
      end
    endcase
    if (st != ST_OK) phys = '0;
    res.status   = st;
    res.phys_out = phys[51:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pwt_res_t want;
    if (!rst_ni) begin
      for (int w = 0; w < TABLE_WORDS; w++) shadow_tables[w] = '0;
      root_base = '0;
      pending_results.delete();
      fails   = 0;
      checked = 0;
    end else begin
      if (res_valid_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no item pending: status %0d", res_i.status);
          fails++;
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (res_i.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, res_i.status);
            fails++;
          end
          if (res_i.phys_out !== want.phys_out) begin
            $error("phys_out mismatch: expected %h, actual %h", want.phys_out,
                   res_i.phys_out);
            fails++;
          end
          if (res_i.large_page !== want.large_page) begin
            $error("large_page mismatch: expected %0d, actual %0d", want.large_page,
                   res_i.large_page);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) root_base = cfg_data_i;
      if (start_i && !busy_i) pending_results.push_back(predict_walk_result(req_i));
    end
    outstanding_o <= pending_results.size();
    fail_count_o  <= fails;
    checked_o     <= checked;
  end

endmodule

// ===== sim/four_level_page_table_walker_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_top_tb
// builds page tables in the walker's store and drives translate, unmap and
// map items against them under several root bases; a checker beside the
// block predicts and compares every result
// ----------------------------------------------------------------------------
module four_level_page_table_walker_top_tb;
  import pwt_pkg::*;

  localparam int TABLE_WORDS  = 4096;
  localparam int RANDOM_ITEMS = 1500;
  // clearing pass plus ~2000 items at worst-case walk time and gaps, many times over
  localparam int LIMIT_CYCLES = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  pwt_req_t    req;
  logic        res_valid;
  pwt_res_t    res;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [51:0] cfg_data;

  int outstanding;
  int fail_count;
  int checked;

  // stimulus bookkeeping
  bit          idle_en;
  int          mode_count [4];
  int          items_sent;
  int          cfg_writes;
  int          cycle_count;
  logic [39:0] root_page;        // root base bits 51:12, where the PML4 sits
  logic [8:0]  idx_pool [4][3];  // per-level index choices of the current phase

  four_level_page_table_walker_top #(
    .TABLE_WORDS(TABLE_WORDS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .res_valid_o(res_valid),
    .res_o      (res),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  pwt_walk_checker #(
    .TABLE_WORDS(TABLE_WORDS)
  ) walk_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .res_valid_i  (res_valid),
    .res_i        (res),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .outstanding_o(outstanding),
    .fail_count_o (fail_count),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // item builders
  // ---------------------------------------------------------------------------

  // every field random, so fields the mode ignores still toggle all bits
  function automatic pwt_req_t noise_req();
    pwt_req_t r;
    r.mode       = 2'($urandom);
    r.word_index = 12'($urandom);
    r.word_value = {$urandom, $urandom};
    r.virt_addr  = {$urandom, $urandom};
    r.phys_addr  = 52'({$urandom, $urandom});
    r.page_flags = 12'($urandom);
    r.no_execute = 1'($urandom);
    return r;
  endfunction

  // virtual address from four level indices; the sign-extension bits are junk
  function automatic logic [63:0] va_of(input logic [8:0] l4, input logic [8:0] l3,
                                        input logic [8:0] l2, input logic [8:0] l1,
                                        input logic [11:0] ofs);
    return {16'($urandom), l4, l3, l2, l1, ofs};
  endfunction

  // table entry with random NX and high bits, which must never leak into addresses
  function automatic logic [63:0] make_entry(input logic [39:0] page,
                                             input logic [11:0] flags);
    return {1'($urandom), 11'($urandom), page, flags};
  endfunction

  // mostly a page inside the store, sometimes one just past it or far away
  function automatic logic [39:0] pick_page();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85) return 40'($urandom_range(7));
    if (roll < 95) return 40'($urandom_range(15, 8));
    return {8'($urandom), $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // channel tasks
  // ---------------------------------------------------------------------------

  // one transaction on the item channel, then a random gap; start stays high
  // across back-to-back items so it is never lowered and raised in one step
  task automatic send_item(input pwt_req_t r);
    req   <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    mode_count[r.mode]++;
    items_sent++;
    while (idle_en && $urandom_range(99) < 37) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic table_write(input logic [11:0] word, input logic [63:0] value);
    pwt_req_t r;
    r            = noise_req();
    r.mode       = MODE_WRITE;
    r.word_index = word;
    r.word_value = value;
    send_item(r);
  endtask

  task automatic walk_item(input logic [1:0] mode, input logic [63:0] va);
    pwt_req_t r;
    r           = noise_req();
    r.mode      = mode;
    r.virt_addr = va;
    send_item(r);
  endtask

  task automatic map_item(input logic [63:0] va, input logic [51:0] pa,
                          input logic [11:0] flags, input logic nx);
    pwt_req_t r;
    r            = noise_req();
    r.mode       = MODE_MAP;
    r.virt_addr  = va;
    r.phys_addr  = pa;
    r.page_flags = flags;
    r.no_execute = nx;
    send_item(r);
  endtask

  // stop issuing and wait until every result has come back; the checker's
  // count is registered, hence the first clock
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // root base register, written only with the walker idle
  task automatic write_root(input logic [51:0] value);
    drain();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    root_page = value[51:12];
  endtask

  // ---------------------------------------------------------------------------
  // random sequences
  // ---------------------------------------------------------------------------

  task automatic new_pools();
    int roll;
    for (int l = 0; l < 4; l++) begin
      for (int k = 0; k < 3; k++) begin
        roll = $urandom_range(5);
        if (roll == 0)      idx_pool[l][k] = 9'h000;
        else if (roll == 1) idx_pool[l][k] = 9'h1FF;
        else                idx_pool[l][k] = 9'($urandom);
      end
    end
  endtask

  // link a PML4 -> PDPT -> PD path from the current root, then walk it with
  // a few map, translate and unmap items; links are sometimes left out or
  // not present so the walk also stops at each level
  task automatic run_path_sequence();
    logic [8:0]  ix [4];
    logic [39:0] parent;
    logic [39:0] child;
    logic [11:0] flags;
    logic [8:0]  leaf;
    logic [11:0] ofs;
    logic [51:0] pa;
    int          roll;
    for (int l = 0; l < 4; l++) ix[l] = idx_pool[l][$urandom_range(2)];
    parent = root_page;
    for (int l = 0; l < 3; l++) begin
      child = pick_page();
      flags = 12'($urandom);
      flags[BIT_PRESENT] = ($urandom_range(9) != 0);
      // large bit means a 2MB page at PD level only; above it the bit stays random
      if (l == 2) flags[BIT_LARGE] = ($urandom_range(3) == 0);
      if (parent < 8 && $urandom_range(9) != 0)
        table_write(12'(parent * 512 + ix[l]), make_entry(child, flags));
      parent = child;
    end
    repeat ($urandom_range(6, 2)) begin
      leaf = ($urandom_range(1) != 0) ? ix[3] : idx_pool[3][$urandom_range(2)];
      ofs  = 12'($urandom);
      roll = $urandom_range(99);
      if (roll < 35) begin
        pa = {pick_page(), 12'h000};
        if ($urandom_range(9) == 0) begin
          // misaligned map, on either address
          if ($urandom_range(1) != 0) pa[11:0] = 12'($urandom_range(4095, 1));
          else ofs = 12'($urandom_range(4095, 1));
        end else begin
          ofs = '0;
        end
        map_item(va_of(ix[0], ix[1], ix[2], leaf, ofs), pa, 12'($urandom), 1'($urandom));
      end else if (roll < 75) begin
        walk_item(MODE_TRANSLATE, va_of(ix[0], ix[1], ix[2], leaf, ofs));
      end else begin
        walk_item(MODE_UNMAP, va_of(ix[0], ix[1], ix[2], leaf, ofs));
      end
    end
  endtask

  // loose item: any mode with random content, addresses often from the pools
  task automatic run_loose_item();
    pwt_req_t r;
    r = noise_req();
    if ($urandom_range(1) != 0)
      r.virt_addr = va_of(idx_pool[0][$urandom_range(2)], idx_pool[1][$urandom_range(2)],
                          idx_pool[2][$urandom_range(2)], idx_pool[3][$urandom_range(2)],
                          12'($urandom));
    if (r.mode == MODE_MAP && $urandom_range(3) != 0) begin
      r.virt_addr[11:0] = '0;
      r.phys_addr[11:0] = '0;
    end
    send_item(r);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int          directed_items;
    int          phase;
    logic [51:0] root;
    rst_ni    = 1'b0;
    start     = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    idle_en   = 1'b1;
    root_page = '0;
    new_pools();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // paging not set up yet: root base is zero after reset
    walk_item(MODE_TRANSLATE, va_of(5, 6, 7, 8, 12'h123));
    walk_item(MODE_UNMAP, va_of(5, 6, 7, 8, 12'h000));
    map_item(va_of(5, 6, 7, 8, 12'h001), {40'd5, 12'h000}, 12'h003, 1'b0);  // alignment first
    map_item(va_of(5, 6, 7, 8, 12'h000), {40'd5, 12'h000}, 12'h003, 1'b0);

    // PML4 at page 1 (low base bits set but ignored), PDPT page 2, PD page 3, PT page 4
    write_root(52'h0_0000_0000_1ABC);
    table_write(12'(512 + 5), {1'b1, 11'h7FF, 40'd2, 12'h007});
    table_write(12'(1024 + 6), make_entry(40'd3, 12'h003));
    table_write(12'(1536 + 7), make_entry(40'd4, 12'h001));
    table_write(12'(1536 + 9), {1'b0, 11'h000, 40'hFF_FFFF_FFFF, 12'h081});  // 2MB page
    table_write(12'(2048 + 8), {1'b1, 11'h7FF, 40'hFF_FFFF_FFFF, 12'hFFF});
    walk_item(MODE_TRANSLATE, va_of(5, 6, 7, 8, 12'hFFF));
    walk_item(MODE_TRANSLATE, va_of(5, 6, 9, 9'h1FF, 12'hFFF));  // 2MB, top offset
    walk_item(MODE_TRANSLATE, va_of(5, 6, 7, 9, 12'h000));       // PT entry absent
    walk_item(MODE_TRANSLATE, va_of(4, 6, 7, 8, 12'h000));       // PML4 entry absent
    walk_item(MODE_TRANSLATE, va_of(5, 7, 7, 8, 12'h000));       // PDPT entry absent
    walk_item(MODE_TRANSLATE, va_of(5, 6, 8, 8, 12'h000));       // PD entry absent
    map_item(va_of(5, 6, 7, 9'h1FF, 12'h000), 52'hF_FFFF_FFFF_F000, 12'hFFF, 1'b1);
    walk_item(MODE_TRANSLATE, va_of(5, 6, 7, 9'h1FF, 12'h800));
    map_item(va_of(5, 6, 9, 3, 12'h000), {40'd6, 12'h000}, 12'h002, 1'b0);  // hits 2MB page
    map_item(va_of(5, 6, 7, 10, 12'h000), 52'h0_0000_0000_7801, 12'h002, 1'b0);
    walk_item(MODE_UNMAP, va_of(5, 6, 7, 100, 12'h000));  // PT entry cleared though absent
    walk_item(MODE_UNMAP, va_of(5, 6, 7, 8, 12'h000));
    walk_item(MODE_TRANSLATE, va_of(5, 6, 7, 8, 12'h000));
    walk_item(MODE_UNMAP, va_of(5, 6, 9, 0, 12'h000));    // clears the 2MB PD entry
    walk_item(MODE_TRANSLATE, va_of(5, 6, 9, 0, 12'h000));
    // PD entry pointing at the page just past the store
    table_write(12'(1536 + 11), make_entry(40'd8, 12'h001));
    walk_item(MODE_TRANSLATE, va_of(5, 6, 11, 0, 12'h000));
    table_write(12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    table_write(12'h000, 64'h0);
    // largest root base: the PML4 lies outside the store
    write_root(52'hF_FFFF_FFFF_FFFF);
    walk_item(MODE_TRANSLATE, va_of(0, 0, 0, 0, 12'h000));
    map_item(va_of(0, 0, 0, 0, 12'h000), 52'h0, 12'h000, 1'b0);
    directed_items = items_sent;

    // random phases, each under its own root base; the first few take the
    // extremes, one phase runs without any idle cycles
    phase = 0;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      new_pools();
      case (phase)
        0:       root = '0;                                    // paging off
        1:       root = 52'hF_FFFF_FFFF_FFFF;                  // PML4 outside store
        2:       root = 52'(12'($urandom_range(4095, 1)));     // nonzero, PML4 at page 0
        3:       root = {40'd8, 12'($urandom)};                // just past the store
        default: begin
          if ($urandom_range(6) == 0) root = 52'({$urandom, $urandom});
          else root = {40'($urandom_range(7)), 12'($urandom)};
        end
      endcase
      idle_en = (phase != 5);
      write_root(root);
      repeat (30) begin
        if ($urandom_range(9) < 7) run_path_sequence();
        else run_loose_item();
      end
      phase++;
    end

    drain();
    repeat (8) @(posedge clk_i);
    $display("ran %0d items: %0d table writes, %0d translates, %0d unmaps, %0d maps",
             items_sent, mode_count[MODE_WRITE], mode_count[MODE_TRANSLATE],
             mode_count[MODE_UNMAP], mode_count[MODE_MAP]);
    $display("%0d root base settings, %0d results compared", cfg_writes, checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
